@@ hw/rtl/cte_pkg.sv @@
`timescale 1ns / 1ps
package cte_pkg;
    typedef struct packed {
        logic        zero_request;
        logic [23:0] gyro_z;
        logic [23:0] gyro_y;
        logic [15:0] accel_z;
        logic [15:0] accel_y;
        logic [15:0] accel_x;
    } sample_t;

    typedef struct packed {
        logic        accel_ok;
        logic [31:0] rel_z;
        logic [31:0] rel_y;
        logic [31:0] ref_z;
        logic [31:0] ref_y;
        logic [31:0] tilt_z;
        logic [31:0] tilt_y;
    } result_t;

    localparam logic CFG_GYRO_GAIN    = 1'b0;
    localparam logic CFG_BLEND_WEIGHT = 1'b1;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001; default: r = 32'h00000000;
        endcase
        return r;
    endfunction
endpackage

@@ hw/rtl/cte_queue.sv @@
`timescale 1ns / 1ps
module cte_queue import cte_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sample_t         in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sample_t         out_data
);
    sample_t    mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    logic push, pop;
    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ hw/rtl/cte_back.sv @@
`timescale 1ns / 1ps
module cte_back import cte_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] gyro_gain,
    input  logic [16:0] blend_weight,
    input  logic        in_valid,
    output logic        in_ready,
    input  sample_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_data
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CORD  = 6'b000010,
        S_GMUL  = 6'b000100,
        S_BMUL  = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t      state_reg;
    sample_t     smp_reg;
    logic        axis_reg;
    logic [4:0]  it_reg;
    logic signed [49:0] x_reg, y_reg;
    logic [31:0] z_reg, acc_y_reg, acc_z_reg, py_reg, pz_reg;
    logic [31:0] tilt_y_reg, tilt_z_reg, ref_y_reg, ref_z_reg;
    logic        started_reg, refset_reg, valid_reg;
    result_t     res_reg;
    logic signed [56:0] prod_reg;

    logic signed [16:0] nx, yin;
    logic signed [49:0] xs, ys;
    logic [31:0] zs;
    logic [4:0]  last_it;
    logic        axis_zero;
    logic [16:0] w_sat;
    logic [31:0] innov, q16;
    logic [31:0] rnd_in;

    assign last_it = 5'(CORDIC_STEPS - 1);
    assign nx  = -{smp_reg.accel_x[15], smp_reg.accel_x};
    assign yin = axis_reg ? {smp_reg.accel_y[15], smp_reg.accel_y}
                          : {smp_reg.accel_z[15], smp_reg.accel_z};
    assign axis_zero = (nx == 17'sd0) && (yin == 17'sd0);
    assign w_sat = (blend_weight > 17'd65536) ? 17'd65536 : blend_weight;
    assign innov = (axis_reg ? acc_z_reg - pz_reg : acc_y_reg - py_reg);
    assign q16 = 32'((prod_reg + 57'sd32768) >>> 16);
    assign rnd_in = q16;

    always_comb begin
        xs = {{17{nx[16]}}, nx, 16'd0};
        ys = {{17{yin[16]}}, yin, 16'd0};
        zs = 32'd0;
        if (nx[16]) begin
            if (!yin[16]) begin
                xs = ys; ys = -{{17{nx[16]}}, nx, 16'd0}; zs = 32'h40000000;
            end else begin
                xs = -ys; ys = {{17{nx[16]}}, nx, 16'd0}; zs = 32'hC0000000;
            end
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
            refset_reg  <= 1'b0;
            tilt_y_reg  <= 32'd0;
            tilt_z_reg  <= 32'd0;
            ref_y_reg   <= 32'd0;
            ref_z_reg   <= 32'd0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (in_valid) begin
                    smp_reg   <= in_data;
                    valid_reg <= |{in_data.accel_x, in_data.accel_y, in_data.accel_z};
                    axis_reg  <= 1'b0;
                    it_reg    <= 5'd0;
                    state_reg <= S_CORD;
                    x_reg     <= 50'sd0;
                    y_reg     <= 50'sd0;
                end
                S_CORD: begin
                    logic signed [49:0] cx, cy;
                    logic [31:0] cz, nz;
                    cx = (it_reg == 5'd0) ? xs : x_reg;
                    cy = (it_reg == 5'd0) ? ys : y_reg;
                    cz = (it_reg == 5'd0) ? zs : z_reg;
                    if (!cy[49]) begin
                        x_reg <= cx + (cy >>> it_reg);
                        y_reg <= cy - (cx >>> it_reg);
                        nz = cz + atan_lut(it_reg);
                    end else begin
                        x_reg <= cx - (cy >>> it_reg);
                        y_reg <= cy + (cx >>> it_reg);
                        nz = cz - atan_lut(it_reg);
                    end
                    z_reg <= nz;
                    if (it_reg == last_it) begin
                        if (axis_reg) acc_z_reg <= axis_zero ? 32'd0 : nz;
                        else          acc_y_reg <= axis_zero ? 32'd0 : nz;
                        it_reg <= 5'd0;
                        if (axis_reg) begin
                            axis_reg  <= 1'b0;
                            prod_reg  <= $signed({{33{smp_reg.gyro_y[23]}}, smp_reg.gyro_y})
                                         * $signed({25'd0, gyro_gain});
                            state_reg <= S_GMUL;
                        end else begin
                            axis_reg <= 1'b1;
                        end
                    end else begin
                        it_reg <= it_reg + 5'd1;
                    end
                end
                S_GMUL: begin
                    if (!axis_reg) begin
                        py_reg   <= tilt_y_reg + rnd_in;
                        prod_reg <= $signed({{33{smp_reg.gyro_z[23]}}, smp_reg.gyro_z})
                                    * $signed({25'd0, gyro_gain});
                        axis_reg <= 1'b1;
                    end else begin
                        pz_reg    <= tilt_z_reg + rnd_in;
                        axis_reg  <= 1'b0;
                        state_reg <= S_BMUL;
                        it_reg    <= 5'd0;
                    end
                end
                S_BMUL: begin
                    if (it_reg == 5'd0) begin
                        prod_reg <= $signed({{25{innov[31]}}, innov})
                                    * $signed({40'd0, w_sat});
                        it_reg   <= 5'd1;
                    end else if (!axis_reg) begin
                        py_reg   <= valid_reg ? py_reg + rnd_in : py_reg;
                        axis_reg <= 1'b1;
                        it_reg   <= 5'd0;
                    end else begin
                        pz_reg    <= valid_reg ? pz_reg + rnd_in : pz_reg;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    logic [31:0] ty, tz, ry, rz;
                    if (!started_reg) begin
                        ty = valid_reg ? acc_y_reg : 32'd0;
                        tz = valid_reg ? acc_z_reg : 32'd0;
                    end else begin
                        ty = py_reg; tz = pz_reg;
                    end
                    ry = ref_y_reg; rz = ref_z_reg;
                    if (smp_reg.zero_request) begin
                        if (valid_reg) begin ty = acc_y_reg; tz = acc_z_reg; end
                        ry = ty; rz = tz;
                    end
                    if (!refset_reg) begin ry = ty; rz = tz; end
                    tilt_y_reg <= ty; tilt_z_reg <= tz;
                    ref_y_reg  <= ry; ref_z_reg  <= rz;
                    started_reg <= 1'b1;
                    refset_reg  <= 1'b1;
                    res_reg <= '{accel_ok: valid_reg, rel_z: tz - rz, rel_y: ty - ry,
                                 ref_z: rz, ref_y: ry, tilt_z: tz, tilt_y: ty};
                    state_reg <= S_OUT;
                end
                S_OUT: if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/complementary_tilt_estimator_unit.sv @@
`timescale 1ns / 1ps
// channel  | dir | handshake              | payload
// s_axis   | in  | s_tvalid / s_tready    | s_tdata, s_tuser
// m_axis   | out | m_tvalid / m_tready    | m_tdata
// cfg      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
// The back end has a shared CORDIC stage that runs both angles in turn. A two-word
// queue lets the front keep taking words while the back works or waits on
// m_tready. Reset is synchronous on aresetn low; tilt, reference and flags clear.
module complementary_tilt_estimator_unit import cte_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,  // accel_x, accel_y, accel_z, gyro_y, gyro_z
    input  logic         s_tuser,  // zero_request
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,  // tilt_y, tilt_z, ref_y, ref_z, rel_y, rel_z, accel_ok
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    logic [31:0] gyro_gain_reg;
    logic [16:0] blend_weight_reg;
    sample_t     smp, q_data;
    logic        q_valid, q_ready;
    result_t     res;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_gain_reg    <= 32'd13670810;
            blend_weight_reg <= 17'd1311;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GYRO_GAIN:    gyro_gain_reg    <= cfg_data;
                CFG_BLEND_WEIGHT: blend_weight_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign smp = {s_tuser, s_tdata};

    cte_queue u_queue (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(smp),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    cte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk, .aresetn,
        .gyro_gain(gyro_gain_reg), .blend_weight(blend_weight_reg),
        .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
    );

    assign m_tdata = {7'd0, res};
endmodule

@@ hw/rtl/cte_checker.sv @@
`timescale 1ns / 1ps
module cte_props (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [199:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
    a_rel_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[159:128] == m_tdata[31:0] - m_tdata[95:64])
        else $error("rel_y");
    a_rel_z: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[191:160] == m_tdata[63:32] - m_tdata[127:96])
        else $error("rel_z");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[199:193] == 7'd0) else $error("pad");
endmodule

bind complementary_tilt_estimator_unit cte_props u_chk (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata
);

@@ tb/sv/cte_checker.sv @@
`timescale 1ns / 1ps
module cte_checker import cte_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [199:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending
);
    localparam int STEPS = 24;

    logic [31:0] gain_q16;
    logic [16:0] weight_q16;
    logic [31:0] tilt_y_st, tilt_z_st, ref_y_st, ref_z_st;
    logic        started_st, ref_set_st;
    result_t     tilt_q[$];

    function automatic logic [63:0] asr(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] round_q16(input logic signed [63:0] p);
        logic [63:0] u;
        u = p + 64'sd32768;
        return u[47:16];
    endfunction

    function automatic logic [31:0] vector_angle(input logic signed [31:0] yi,
                                                 input logic signed [31:0] xi);
        logic signed [63:0] x, y, t, dx, dy;
        logic [31:0] z;
        z = 32'h0;
        x = 64'(xi) * 65536;
        y = 64'(yi) * 65536;
        if (xi == 0 && yi == 0) return 32'h0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 32'h40000000;
            end else begin
                x = -y; y = t; z = 32'hC0000000;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_lut(i[4:0]);
            end else begin
                x -= dx; y += dy; z -= atan_lut(i[4:0]);
            end
        end
        return z;
    endfunction

    function automatic logic [31:0] blend_angle(input logic [31:0] pred,
                                                input logic [31:0] meas);
        logic signed [63:0] innov;
        logic [31:0] d;
        logic [16:0] w;
        d = meas - pred;
        innov = 64'(signed'(d));
        w = (weight_q16 > 17'd65536) ? 17'd65536 : weight_q16;
        return pred + round_q16(innov * $signed({47'd0, w}));
    endfunction

    task automatic predict_tilt(input sample_t smp);
        logic signed [31:0] ax, ay, az;
        logic signed [63:0] gy, gz;
        logic        valid;
        logic [31:0] acc_y, acc_z, py, pz;
        result_t     res;
        ax = 32'(signed'(smp.accel_x));
        ay = 32'(signed'(smp.accel_y));
        az = 32'(signed'(smp.accel_z));
        gy = 64'(signed'(smp.gyro_y));
        gz = 64'(signed'(smp.gyro_z));
        valid = !(ax == 0 && ay == 0 && az == 0);
        acc_y = 32'h0;
        acc_z = 32'h0;
        if (valid) begin
            acc_y = vector_angle(az, -ax);
            acc_z = vector_angle(ay, -ax);
        end
        if (!started_st) begin
            tilt_y_st = valid ? acc_y : 32'h0;
            tilt_z_st = valid ? acc_z : 32'h0;
            started_st = 1'b1;
        end else begin
            py = tilt_y_st + round_q16(gy * $signed({32'd0, gain_q16}));
            pz = tilt_z_st + round_q16(gz * $signed({32'd0, gain_q16}));
            tilt_y_st = valid ? blend_angle(py, acc_y) : py;
            tilt_z_st = valid ? blend_angle(pz, acc_z) : pz;
        end
        if (smp.zero_request) begin
            if (valid) begin
                tilt_y_st = acc_y;
                tilt_z_st = acc_z;
            end
            ref_y_st = tilt_y_st;
            ref_z_st = tilt_z_st;
            started_st = 1'b1;
            ref_set_st = 1'b1;
        end
        if (!ref_set_st) begin
            ref_y_st = tilt_y_st;
            ref_z_st = tilt_z_st;
            ref_set_st = 1'b1;
        end
        res.tilt_y = tilt_y_st;
        res.tilt_z = tilt_z_st;
        res.ref_y = ref_y_st;
        res.ref_z = ref_z_st;
        res.rel_y = tilt_y_st - ref_y_st;
        res.rel_z = tilt_z_st - ref_z_st;
        res.accel_ok = valid;
        tilt_q.push_back(res);
    endtask

    task automatic compare_result(input result_t got);
        result_t want;
        bit bad;
        if (tilt_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected word %h", got);
            return;
        end
        want = tilt_q.pop_front();
        bad = (got.tilt_y != want.tilt_y) || (got.tilt_z != want.tilt_z)
            || (got.ref_y != want.ref_y) || (got.ref_z != want.ref_z)
            || (got.rel_y != want.rel_y) || (got.rel_z != want.rel_z)
            || (got.accel_ok != want.accel_ok);
        if (bad) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch: expected %h actual %h", want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            gain_q16 <= 32'd13670810;
            weight_q16 <= 17'd1311;
            tilt_y_st = 32'h0; tilt_z_st = 32'h0; ref_y_st = 32'h0; ref_z_st = 32'h0;
            started_st = 1'b0; ref_set_st = 1'b0;
            fail_count = 0;
            tilt_q.delete();
        end else begin
            if (m_tvalid && m_tready) compare_result(result_t'(m_tdata[192:0]));
            if (s_tvalid && s_tready) predict_tilt(sample_t'({s_tuser, s_tdata}));
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_GYRO_GAIN) gain_q16 <= cfg_data;
                else weight_q16 <= cfg_data[16:0];
            end
        end
        pending = tilt_q.size();
    end
endmodule

@@ tb/sv/tb_complementary_tilt_estimator_unit.sv @@
`timescale 1ns / 1ps
module tb_complementary_tilt_estimator_unit import cte_pkg::*;;
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [199:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = CFG_GYRO_GAIN;
    logic [31:0]  cfg_data = '0;
    int           fail_count, pending;
    bit           calm = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    complementary_tilt_estimator_unit dut (.*);

    cte_checker chk (.*);

    initial begin
        #200_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always begin
        int n;
        @(posedge aclk);
        if (!calm && $urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
        end
        m_tready <= 1'b1;
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(input logic [15:0] ax, ay, az,
                               input logic [23:0] gy, gz, input logic zr);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {gz, gy, az, ay, ax};
        s_tuser <= zr;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0;
            3: return 16'(signed'($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_rate();
        case ($urandom_range(0, 4))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'(signed'($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_block(input int cnt);
        for (int i = 0; i < cnt; i++)
            send_sample(rand_axis(), rand_axis(), rand_axis(), rand_rate(), rand_rate(),
                        $urandom_range(0, 15) == 0);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // invalid first sample, then directed extremes
        send_sample(16'h0, 16'h0, 16'h0, 24'h7FFFFF, 24'h800000, 1'b0);
        send_sample(16'h0, 16'h0, 16'h0, 24'h7FFFFF, 24'h800000, 1'b0);
        send_sample(16'h0, 16'h0, 16'h0, 24'h000001, 24'hFFFFFF, 1'b1);
        send_sample(16'h8000, 16'h0, 16'h0, 24'h0, 24'h0, 1'b0);
        send_sample(16'h7FFF, 16'h0, 16'h0, 24'h0, 24'h0, 1'b1);
        send_sample(16'h0, 16'h7FFF, 16'h8000, 24'h0, 24'h0, 1'b0);
        send_sample(16'h0, 16'h8000, 16'h7FFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_sample(16'h8000, 16'h8000, 16'h8000, 24'h800000, 24'h800000, 1'b1);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h0, 24'h0, 1'b0);
        send_sample(16'h0001, 16'hFFFF, 16'h0, 24'h5A5A5A, 24'hA5A5A5, 1'b0);
        send_sample(16'hFFFF, 16'h0001, 16'h0001, 24'h123456, 24'hEDCBA9, 1'b1);
        random_block(150);
        drain();
        write_reg(CFG_GYRO_GAIN, 32'hFFFFFFFF);
        write_reg(CFG_BLEND_WEIGHT, 32'h1FFFF);
        random_block(250);
        drain();
        write_reg(CFG_GYRO_GAIN, 32'h0);
        write_reg(CFG_BLEND_WEIGHT, 32'h0);
        random_block(250);
        drain();
        write_reg(CFG_GYRO_GAIN, 32'h00010000);
        write_reg(CFG_BLEND_WEIGHT, 32'd65536);
        random_block(250);
        drain();
        write_reg(CFG_GYRO_GAIN, $urandom);
        write_reg(CFG_BLEND_WEIGHT, $urandom_range(0, 65536));
        random_block(250);
        drain();
        write_reg(CFG_GYRO_GAIN, 32'd13670810);
        write_reg(CFG_BLEND_WEIGHT, 32'd65537);
        random_block(350);
        calm = 1;
        random_block(250);
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
